### hdl/mtf_pkg.sv
// ----------------------------------------------------------------------------
// mtf_pkg
// Shared constants and types for the move-to-front list.
// ----------------------------------------------------------------------------
`default_nettype none

package mtf_pkg;

    // list capacity (2 .. 256)
    localparam int DEPTH    = 16;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int DATA_W   = 32;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;

    localparam logic [CNT_W-1:0] LEN_FULL = CNT_W'(DEPTH);

    // operation codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] position;
        logic             refused;
        logic [CNT_W-1:0] count;
    } t_res;

endpackage

`default_nettype wire

### hdl/move_to_front_list_top.sv
// ----------------------------------------------------------------------------
// move_to_front_list_top
// Bounded move-to-front list of signed 32-bit values.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall, i_func, i_value): one beat is one
//   operation. i_func = insert puts i_value at the front; i_func = search
//   looks for the first equal entry and moves it to the front.
//   Output channel (o_valid / i_stall): one result beat per input beat with
//   o_found, o_position (index of the hit before the move), o_refused (insert
//   into a full list) and o_count (entries held afterwards).
//   One item at a time. The entries sit in a RAM with one read and one
//   write port; a single comparator walks them from the front (read, then
//   compare), and the shift walks back from the hit or the end (read, then
//   write) before the value is written at the front.
//   o_stall is high from acceptance until the result moves to the output
//   register.
//   Reset clears the length to zero; RAM contents are not cleared (only
//   entries below the length are ever read).
//   A stalled result holds in the output register; the sequencer finishes
//   its work and waits in its done state until the slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

module move_to_front_list_top
    import mtf_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic                     i_func,
    input  wire logic signed [DATA_W-1:0] i_value,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic                          o_found,
    output logic [POS_W-1:0]              o_position,
    output logic                          o_refused,
    output logic [COUNT_W-1:0]            o_count
);

    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
    logic [DATA_W-1:0] rdata;
    logic              seq_done;
    t_res              seq_res;
    logic              res_free;

    // output slot: r_ register holding one result beat
    logic              r_valid;
    logic              r_found;
    logic [POS_W-1:0]  r_position;
    logic              r_refused;
    logic [COUNT_W-1:0] r_count;

    mtf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    mtf_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_func     (i_func),
        .i_value    (i_value),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_raddr    (raddr),
        .i_rdata    (rdata),
        .i_res_free (res_free),
        .o_done     (seq_done),
        .o_res      (seq_res)
    );

    // slot is free when empty or being drained this cycle
    assign res_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (seq_done) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
        if (seq_done) begin
            // position and count wrap to their field widths
            r_found    <= seq_res.found;
            r_position <= POS_W'(seq_res.position);
            r_refused  <= seq_res.refused;
            r_count    <= COUNT_W'(seq_res.count);
        end
    end

    assign o_valid    = r_valid;
    assign o_found    = r_found;
    assign o_position = r_position;
    assign o_refused  = r_refused;
    assign o_count    = r_count;

endmodule

`default_nettype wire

### hdl/mtf_ram.sv
// ----------------------------------------------------------------------------
// mtf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mtf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### hdl/mtf_seq.sv
// ----------------------------------------------------------------------------
// mtf_seq
// Sequencer: a search scans the entry RAM with one comparator; a hit behind
// the front, or an insert, shifts entries back one slot and writes the front.
// ----------------------------------------------------------------------------
`default_nettype none

module mtf_seq
    import mtf_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // input beat
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic                     i_func,
    input  wire logic signed [DATA_W-1:0] i_value,
    // entry RAM
    output logic                          o_we,
    output logic [IDX_W-1:0]              o_waddr,
    output logic [DATA_W-1:0]             o_wdata,
    output logic [IDX_W-1:0]              o_raddr,
    input  wire logic [DATA_W-1:0]        i_rdata,
    // result
    input  wire logic                     i_res_free,
    output logic                          o_done,
    output t_res                          o_res
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SC_RD = 3'd1;
    localparam logic [2:0] ST_SC_CP = 3'd2;
    localparam logic [2:0] ST_SH_RD = 3'd3;
    localparam logic [2:0] ST_SH_WR = 3'd4;
    localparam logic [2:0] ST_FRONT = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0]        r_state, n_state;
    logic              r_func, n_func;
    logic [DATA_W-1:0] r_value, n_value;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_len, n_len;
    logic              r_hit, n_hit;
    logic [IDX_W-1:0]  r_pos, n_pos;
    logic              r_refused, n_refused;

    always_comb begin
        n_state   = r_state;
        n_func    = r_func;
        n_value   = r_value;
        n_idx     = r_idx;
        n_len     = r_len;
        n_hit     = r_hit;
        n_pos     = r_pos;
        n_refused = r_refused;
        o_we      = 1'b0;
        o_waddr   = r_idx;
        o_wdata   = i_rdata;
        o_raddr   = r_idx;
        o_done    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_func    = i_func;
                    n_value   = i_value;
                    n_hit     = 1'b0;
                    n_pos     = '0;
                    n_refused = 1'b0;
                    n_idx     = '0;
                    if (i_func == FUNC_INSERT) begin
                        if (r_len >= LEN_FULL) begin
                            n_refused = 1'b1;
                            n_state   = ST_DONE;
                        end else begin
                            n_idx   = IDX_W'(r_len);
                            n_state = ST_SH_RD;
                        end
                    end else if (r_len == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_SC_RD;
                    end
                end
            end
            ST_SC_RD: begin
                n_state = ST_SC_CP;
            end
            ST_SC_CP: begin
                if (i_rdata == r_value) begin
                    n_hit   = 1'b1;
                    n_pos   = r_idx;
                    // hit at the front leaves the list as is
                    n_state = (r_idx == '0) ? ST_DONE : ST_SH_RD;
                end else if ((CNT_W'(r_idx) + 1'b1) == r_len) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = ST_SC_RD;
                end
            end
            ST_SH_RD: begin
                o_raddr = r_idx - 1'b1;
                n_state = (r_idx == '0) ? ST_FRONT : ST_SH_WR;
            end
            ST_SH_WR: begin
                o_we    = 1'b1;
                o_waddr = r_idx;
                o_wdata = i_rdata;
                n_idx   = r_idx - 1'b1;
                n_state = ST_SH_RD;
            end
            ST_FRONT: begin
                o_we    = 1'b1;
                o_waddr = '0;
                o_wdata = r_value;
                if (r_func == FUNC_INSERT) begin
                    n_len = r_len + 1'b1;
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_res_free) begin
                    o_done  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_len   <= '0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
        end
        r_func    <= n_func;
        r_value   <= n_value;
        r_idx     <= n_idx;
        r_hit     <= n_hit;
        r_pos     <= n_pos;
        r_refused <= n_refused;
    end

    assign o_stall        = (r_state != ST_IDLE);
    assign o_res.found    = r_hit;
    assign o_res.position = r_pos;
    assign o_res.refused  = r_refused;
    assign o_res.count    = r_len;

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_FULL)
        else $error("list length above capacity");

    a_done_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> i_res_free)
        else $error("result issued while output slot busy");

    a_refused_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.refused) |-> (r_len == LEN_FULL && !o_res.found))
        else $error("insert refused with room left");

    a_hit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.found) |-> (CNT_W'(o_res.position) < r_len))
        else $error("hit position beyond list length");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && !i_valid) |=> (r_state == ST_IDLE))
        else $error("sequencer left idle without a beat");

endmodule

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the move-to-front list: directed and random inserts
// and searches against a scoreboard that keeps its own copy of the list.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic                        found;
    logic [mtf_pkg::POS_W-1:0]   position;
    logic                        refused;
    logic [mtf_pkg::COUNT_W-1:0] count;
} mtf_result_t;

class mtf_scoreboard;
    localparam int MAX_REPORTS = 100;

    logic [mtf_pkg::DATA_W-1:0] entries [mtf_pkg::DEPTH];
    int unsigned                length;
    mtf_result_t                expected_q [$];
    int unsigned                errors;

    function new();
        length = 0;
        errors = 0;
    endfunction

    function int unsigned pending();
        return expected_q.size();
    endfunction

    // shift [0, upto) back one slot, v goes to the front
    function void move_front(int unsigned upto, logic [mtf_pkg::DATA_W-1:0] v);
        for (int unsigned i = upto; i > 0; i--)
            entries[i] = entries[i-1];
        entries[0] = v;
    endfunction

    function void note_item(logic func, logic [mtf_pkg::DATA_W-1:0] value);
        mtf_result_t res;
        int          hit_at;
        res    = '0;
        hit_at = -1;
        if (func == mtf_pkg::FUNC_INSERT) begin
            if (length >= mtf_pkg::DEPTH) begin
                res.refused = 1'b1;
            end else begin
                move_front(length, value);
                length++;
            end
        end else begin
            for (int i = 0; i < int'(length); i++)
                if (hit_at < 0 && entries[i] == value)
                    hit_at = i;
            if (hit_at >= 0) begin
                res.found    = 1'b1;
                res.position = mtf_pkg::POS_W'(hit_at);
                move_front(hit_at, value);
            end
        end
        res.count = mtf_pkg::COUNT_W'(length);
        expected_q.push_back(res);
    endfunction

    function void flag(string what, longint unsigned exp_v, longint unsigned act_v);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
    endfunction

    function void check_result(mtf_result_t act);
        mtf_result_t exp_r;
        if (expected_q.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: result beat with nothing expected, expected none, actual %h",
                         $time, act);
            return;
        end
        exp_r = expected_q.pop_front();
        if (act.found !== exp_r.found)       flag("found", exp_r.found, act.found);
        if (act.position !== exp_r.position) flag("position", exp_r.position, act.position);
        if (act.refused !== exp_r.refused)   flag("refused", exp_r.refused, act.refused);
        if (act.count !== exp_r.count)       flag("count", exp_r.count, act.count);
    endfunction
endclass

module testbench;
    import mtf_pkg::*;

    localparam int RANDOM_ITEMS = 1830;
    localparam int STUCK_LIMIT  = 2000;   // cycles with no beat on either side
    localparam int HOLD_AT      = 400;    // receiver blocks once at this input count
    localparam int HOLD_CYCLES  = 300;
    localparam int CALM_LO      = 700;    // no idling on either side in this window
    localparam int CALM_HI      = 1000;
    localparam int PAUSE_AT     = 1300;   // sender drains the block here
    localparam int TAIL_CYCLES  = 100;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic                     i_func;
    logic signed [DATA_W-1:0] i_value;
    logic                     o_valid;
    logic                     i_stall;
    logic                     o_found;
    logic [POS_W-1:0]         o_position;
    logic                     o_refused;
    logic [COUNT_W-1:0]       o_count;

    mtf_scoreboard sb;
    int unsigned   items_in     = 0;   // accepted input beats
    int unsigned   stuck_cycles = 0;
    int unsigned   hold_left    = 0;
    bit            hold_done    = 1'b0;

    move_to_front_list_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_func     (i_func),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_found    (o_found),
        .o_position (o_position),
        .o_refused  (o_refused),
        .o_count    (o_count)
    );

    always #4 i_clk = ~i_clk;

    function automatic bit calm_window();
        return items_in >= CALM_LO && items_in < CALM_HI;
    endfunction

    // Both channels are sampled here at the rising edge, before the block's
    // registers move. The input beat is noted first; its result can only come
    // on a later edge anyway.
    always @(posedge i_clk) begin : monitor
        bit took_in;
        bit took_out;
        took_in  = i_rst_n && i_valid && !o_stall;
        took_out = i_rst_n && o_valid && !i_stall;
        if (took_in) begin
            sb.note_item(i_func, i_value);
            items_in++;
        end
        if (took_out)
            sb.check_result('{o_found, o_position, o_refused, o_count});
        stuck_cycles = (took_in || took_out) ? 0 : stuck_cycles + 1;
    end

    // Receiver: random stall about a quarter of the time, none in the calm
    // window, and one long hold-off so the block backs up onto its input.
    initial begin : receiver
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && items_in >= HOLD_AT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else if (calm_window()) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(99) < 25);
            end
        end
    end

    initial begin : watchdog
        wait (stuck_cycles >= STUCK_LIMIT);
        $display("testbench NOT OK");
        $finish;
    end

    // One beat: payload goes out at the falling edge and holds until a rising
    // edge sees o_stall low. Returns on the following falling edge.
    task automatic send_item(input logic func, input logic [DATA_W-1:0] value);
        i_valid <= 1'b1;
        i_func  <= func;
        i_value <= value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // junk on the payload while valid is low
    task automatic idle_cycle();
        i_valid <= 1'b0;
        i_func  <= 1'($urandom);
        i_value <= $urandom;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        idle_cycle();
        while (sb.pending() != 0) idle_cycle();
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 25) begin
            case ($urandom_range(3))
                0:       return 32'h8000_0000;
                1:       return 32'h7fff_ffff;
                2:       return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
        end
        if (roll < 50)
            return DATA_W'($urandom_range(7)) - 32'd4;   // a few small values, dups likely
        return $urandom;
    endfunction

    // Mostly searches that hit somewhere in the list, so hits move entries
    // from every depth; near misses differ from a held value in one bit.
    task automatic pick_item(output logic func, output logic [DATA_W-1:0] value);
        int unsigned len;
        int unsigned roll;
        len  = sb.length;
        roll = $urandom_range(99);
        if (len < DEPTH)
            func = (roll < 40) ? FUNC_INSERT : FUNC_SEARCH;
        else
            func = (roll < 20) ? FUNC_INSERT : FUNC_SEARCH;
        roll = $urandom_range(99);
        if (len > 0 && func == FUNC_SEARCH && roll < 70)
            value = sb.entries[$urandom_range(len - 1)];
        else if (len > 0 && func == FUNC_SEARCH && roll < 85)
            value = sb.entries[$urandom_range(len - 1)] ^ (32'd1 << $urandom_range(31));
        else if (len > 0 && func == FUNC_INSERT && roll < 30)
            value = sb.entries[$urandom_range(len - 1)];
        else
            value = pick_value();
    endtask

    initial begin : stimulus
        logic              func;
        logic [DATA_W-1:0] value;
        sb      = new();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_func  = FUNC_INSERT;
        i_value = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty list, field extremes, hit at front, hit deeper,
        // duplicates, one-bit near miss
        send_item(FUNC_SEARCH, 32'h0000_0000);   // empty list: miss
        send_item(FUNC_INSERT, 32'h8000_0000);
        send_item(FUNC_SEARCH, 32'h8000_0000);   // hit at front
        send_item(FUNC_SEARCH, 32'h7fff_ffff);   // miss
        send_item(FUNC_INSERT, 32'h7fff_ffff);
        send_item(FUNC_INSERT, 32'h0000_0000);
        send_item(FUNC_INSERT, 32'hffff_ffff);
        idle_cycle();
        send_item(FUNC_SEARCH, 32'h8000_0000);   // hit at the back, moves forward
        send_item(FUNC_INSERT, 32'h7fff_ffff);   // duplicate
        send_item(FUNC_SEARCH, 32'h7fff_ffff);   // first copy is at the front
        send_item(FUNC_SEARCH, 32'h0000_0000);
        send_item(FUNC_SEARCH, 32'hffff_fffe);   // one bit off an entry
        send_item(FUNC_SEARCH, 32'h7fff_ffff);   // first copy now behind the front

        // random part: fills the list, then the list stays full (no delete)
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == PAUSE_AT)
                wait_drained();
            if (!calm_window())
                while ($urandom_range(99) < 25) idle_cycle();
            pick_item(func, value);
            send_item(func, value);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (sb.errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
